// ===== rtl/core/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg - shared types and constants of the sorted min priority queue
// Depth, field widths, operation and status codes, and the structs passed
// between the top level and the row of sorting cells.
// ----------------------------------------------------------------------------
package smpq_pkg;

   // storage depth and derived widths
   localparam int SMPQ_DEPTH = 128;
   localparam int COUNT_W    = $clog2(SMPQ_DEPTH + 1);
   localparam int KEY_W      = 32;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // key reported when there is nothing to return
   localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

   // command broadcast to every cell
   typedef struct packed {
      logic                    ins;
      logic                    rem;
      logic signed [KEY_W-1:0] key;
   } cell_cmd_type;

   // what a cell shows its neighbours
   typedef struct packed {
      logic                    valid;
      logic                    take;
      logic signed [KEY_W-1:0] key;
   } cell_out_type;

endpackage

// ===== rtl/core/smpq_if.sv =====
// ----------------------------------------------------------------------------
// smpq_if - request and response channels of the sorted min priority queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface smpq_req_if;
   logic                             valid;
   logic                             ready;
   logic [smpq_pkg::OP_W-1:0]        op;
   logic signed [smpq_pkg::KEY_W-1:0] key_in;

   modport source (output valid, output op, output key_in, input ready);
   modport sink   (input valid, input op, input key_in, output ready);
endinterface

interface smpq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [smpq_pkg::KEY_W-1:0] key_out;
   logic [smpq_pkg::STATUS_W-1:0]     status;
   logic [smpq_pkg::OCC_W-1:0]        occupancy;

   modport source (output valid, output key_out, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input key_out, input status, input occupancy,
                   output ready);
endinterface

// ===== rtl/core/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// smpq_cell - one slot of the sorted key chain
// Holds one key and its valid bit. On insert, every slot above the new key's
// place takes its left neighbour's key; on remove, every slot takes its
// right neighbour's key.
// ----------------------------------------------------------------------------
module smpq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  smpq_pkg::cell_cmd_type cmd,
   input  smpq_pkg::cell_out_type left,
   input  smpq_pkg::cell_out_type right,
   output smpq_pkg::cell_out_type slot
);

   logic                              valid_ff;
   logic                              valid_in;
   logic signed [smpq_pkg::KEY_W-1:0] key_ff;
   logic signed [smpq_pkg::KEY_W-1:0] key_in;
   logic                              take;

   // slot is free or holds a key strictly above the new one
   assign take = !valid_ff || (key_ff > cmd.key);

   // next contents
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (cmd.ins && take) begin
         if (left.take) begin
            valid_in = left.valid;
            key_in   = left.key;
         end else begin
            valid_in = 1'b1;
            key_in   = cmd.key;
         end
      end else if (cmd.rem) begin
         valid_in = right.valid;
         key_in   = right.key;
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // key payload
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign slot.valid = valid_ff;
   assign slot.take  = take;
   assign slot.key   = key_ff;

endmodule

// ===== rtl/core/sorted_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_min_priority_queue - min priority queue on a chain of sorting cells
// Keys sit in ascending order along a row of cells; the head cell holds the
// minimum. Inserts keep equal keys in arrival order.
//
//   channel | direction | beat contents
//   --------+-----------+---------------------------------------
//   req     | in        | op, key_in
//   rsp     | out       | key_out, status, occupancy
//
// One request beat per cycle while responses are taken; the response is
// registered and shows the cycle after acceptance. Every cell updates in
// that single cycle, so the rate is set by the broadcast compare across
// the chain, not by depth. Reset empties the chain at once. A stalled
// response holds req.ready low until the response register is taken.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue (
   input  logic       clock,
   input  logic       reset,
   smpq_req_if.sink   req,
   smpq_rsp_if.source rsp
);

   smpq_pkg::cell_out_type cells [smpq_pkg::SMPQ_DEPTH];
   smpq_pkg::cell_out_type head_left;
   smpq_pkg::cell_out_type tail_right;
   smpq_pkg::cell_cmd_type cmd;

   logic [smpq_pkg::COUNT_W-1:0]      count_ff;
   logic [smpq_pkg::COUNT_W-1:0]      count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [smpq_pkg::KEY_W-1:0] rsp_key_ff;
   logic signed [smpq_pkg::KEY_W-1:0] rsp_key_in;
   logic [smpq_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [smpq_pkg::STATUS_W-1:0]     rsp_status_in;
   logic [smpq_pkg::OCC_W-1:0]        rsp_occ_ff;
   logic [smpq_pkg::OCC_W-1:0]        rsp_occ_in;
   logic                              accept;
   logic                              empty;
   logic                              full;

   // chain boundaries
   assign head_left  = '{valid: 1'b1, take: 1'b0, key: '0};
   assign tail_right = '{valid: 1'b0, take: 1'b0, key: '0};

   assign empty  = !cells[0].valid;
   assign full   = cells[smpq_pkg::SMPQ_DEPTH-1].valid;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;

   // decode the request into a chain command and a response
   always_comb begin
      cmd.ins       = 1'b0;
      cmd.rem       = 1'b0;
      cmd.key       = req.key_in;
      count_in      = count_ff;
      rsp_key_in    = '0;
      rsp_status_in = smpq_pkg::ST_OK;
      case (req.op)
         smpq_pkg::OP_INSERT: begin
            if (full) begin
               rsp_status_in = smpq_pkg::ST_FULL;
            end else begin
               cmd.ins  = accept;
               count_in = count_ff + 1'b1;
            end
         end
         smpq_pkg::OP_REMOVE, smpq_pkg::OP_PEEK: begin
            if (empty) begin
               rsp_key_in    = smpq_pkg::EMPTY_KEY;
               rsp_status_in = smpq_pkg::ST_EMPTY;
            end else begin
               rsp_key_in = cells[0].key;
               if (req.op == smpq_pkg::OP_REMOVE) begin
                  cmd.rem  = accept;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_occ_in   = smpq_pkg::OCC_W'(count_in);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);
   end

   // row of cells
   for (genvar i = 0; i < smpq_pkg::SMPQ_DEPTH; i++) begin : g_cell
      smpq_pkg::cell_out_type left;
      smpq_pkg::cell_out_type right;
      if (i == 0) begin : g_head
         assign left = head_left;
      end else begin : g_mid_l
         assign left = cells[i-1];
      end
      if (i == smpq_pkg::SMPQ_DEPTH - 1) begin : g_tail
         assign right = tail_right;
      end else begin : g_mid_r
         assign right = cells[i+1];
      end
      smpq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (left),
         .right (right),
         .slot  (cells[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_key_ff    <= rsp_key_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.key_out   = rsp_key_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.occupancy = rsp_occ_ff;

endmodule

// ===== dv/tb_sorted_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_min_priority_queue - self-checking bench for the min priority queue
// Drives insert, remove-minimum, peek and unused-op beats through the request
// channel, keeps its own sorted copy of the store to predict every response,
// and checks each response beat field by field in arrival order. Sender and
// receiver idle at random in the first two of three phases, and one long
// receiver hold-off leaves a response waiting so the block stalls its input.
// ----------------------------------------------------------------------------
module tb_sorted_min_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   // spare op code that the block must ignore
   localparam logic [smpq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int TARGET_BEATS = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [smpq_pkg::OP_W-1:0]         op;
      logic signed [smpq_pkg::KEY_W-1:0] key;
   } queue_cmd_type;

   typedef struct {
      logic signed [smpq_pkg::KEY_W-1:0] key;
      logic [smpq_pkg::STATUS_W-1:0]     status;
      logic [smpq_pkg::OCC_W-1:0]        occ;
   } queue_reply_type;

   logic clock;
   logic reset;

   smpq_req_if req_chan ();
   smpq_rsp_if rsp_chan ();

   sorted_min_priority_queue u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   // command backlog and expected replies
   queue_cmd_type   cmd_backlog[$];
   queue_reply_type expected_replies[$];

   // predictor state: ascending copy of the store
   logic signed [smpq_pkg::KEY_W-1:0] model_keys [smpq_pkg::SMPQ_DEPTH];
   int                                model_count = 0;

   // occupancy seen by the stimulus generator
   int gen_count = 0;

   int beats_taken  = 0;
   int phase_len    = TARGET_BEATS / 3;
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   int mismatch_cnt = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // apply one operation to the model store and return the reply it gives
   function automatic queue_reply_type apply_queue_op(
         input logic [smpq_pkg::OP_W-1:0]         op,
         input logic signed [smpq_pkg::KEY_W-1:0] key);
      queue_reply_type r;
      int              pos;
      r.key    = '0;
      r.status = smpq_pkg::ST_OK;
      case (op)
         smpq_pkg::OP_INSERT: begin
            if (model_count >= smpq_pkg::SMPQ_DEPTH) begin
               r.status = smpq_pkg::ST_FULL;
            end else begin
               // larger keys move up, equal keys stay ahead
               pos = model_count;
               while (pos > 0 && model_keys[pos-1] > key) begin
                  model_keys[pos] = model_keys[pos-1];
                  pos--;
               end
               model_keys[pos] = key;
               model_count++;
            end
         end
         smpq_pkg::OP_REMOVE, smpq_pkg::OP_PEEK: begin
            if (model_count == 0) begin
               r.key    = smpq_pkg::EMPTY_KEY;
               r.status = smpq_pkg::ST_EMPTY;
            end else begin
               r.key = model_keys[0];
               if (op == smpq_pkg::OP_REMOVE) begin
                  for (pos = 1; pos < model_count; pos++)
                     model_keys[pos-1] = model_keys[pos];
                  model_count--;
               end
            end
         end
         default: ;
      endcase
      r.occ = model_count[smpq_pkg::OCC_W-1:0];
      return r;
   endfunction

   // idle percentage for each side by phase
   function automatic int idle_pct(input bit sender);
      if (beats_taken < phase_len)
         return sender ? 6 : 84;
      else if (beats_taken < 2 * phase_len)
         return sender ? 84 : 6;
      else
         return 0;
   endfunction

   // queue one command and track the resulting occupancy
   task automatic add_cmd(input logic [smpq_pkg::OP_W-1:0]         op,
                          input logic signed [smpq_pkg::KEY_W-1:0] key);
      queue_cmd_type c;
      c.op  = op;
      c.key = key;
      cmd_backlog.push_back(c);
      if (op == smpq_pkg::OP_INSERT && gen_count < smpq_pkg::SMPQ_DEPTH)
         gen_count++;
      else if (op == smpq_pkg::OP_REMOVE && gen_count > 0)
         gen_count--;
   endtask

   // key drawn from full range, a narrow tie-heavy range or the extremes
   function automatic logic signed [smpq_pkg::KEY_W-1:0] pick_key(input int mode);
      logic signed [smpq_pkg::KEY_W-1:0] k;
      case (mode)
         0: k = $urandom;
         1: k = $signed($urandom_range(16)) - 8;
         default: begin
            case ($urandom_range(5))
               0: k = 32'sh8000_0000;
               1: k = 32'sh7fff_ffff;
               2: k = 32'sh8000_0001;
               3: k = 32'sh7fff_fffe;
               4: k = 0;
               default: k = -1;
            endcase
         end
      endcase
      return k;
   endfunction

   // any op except insert, weighted toward removes
   function automatic logic [smpq_pkg::OP_W-1:0] pick_read_op();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return smpq_pkg::OP_REMOVE;
      else if (r < 90)
         return smpq_pkg::OP_PEEK;
      else
         return OP_UNUSED;
   endfunction

   // stimulus generation, reset, end of run
   initial begin
      int seg;
      int n;
      int mode;
      int r;
      int guard;

      reset = 1'b1;

      // directed: empty queue, extremes, ties, unused op
      add_cmd(smpq_pkg::OP_REMOVE, 32'sh1234_5678);
      add_cmd(smpq_pkg::OP_PEEK, 32'sh8000_0000);
      add_cmd(OP_UNUSED, 32'sh7fff_ffff);
      add_cmd(smpq_pkg::OP_INSERT, 32'sh7fff_ffff);
      add_cmd(smpq_pkg::OP_INSERT, 32'sh8000_0000);
      add_cmd(smpq_pkg::OP_INSERT, 0);
      add_cmd(smpq_pkg::OP_INSERT, -1);
      add_cmd(smpq_pkg::OP_INSERT, 5);
      add_cmd(smpq_pkg::OP_INSERT, 5);
      add_cmd(smpq_pkg::OP_INSERT, -1);
      add_cmd(smpq_pkg::OP_PEEK, '1);
      add_cmd(OP_UNUSED, 32'sh5555_aaaa);
      add_cmd(smpq_pkg::OP_INSERT, 32'sh7fff_ffff);
      add_cmd(smpq_pkg::OP_INSERT, 32'sh8000_0000);
      for (int i = 0; i < 10; i++)
         add_cmd(smpq_pkg::OP_REMOVE, $urandom);
      add_cmd(smpq_pkg::OP_REMOVE, 0);
      add_cmd(smpq_pkg::OP_PEEK, 0);

      // random segments: fill to full, drain to empty, mixed traffic, noise
      seg = 0;
      while (cmd_backlog.size() < TARGET_BEATS) begin
         mode = $urandom_range(2);
         if (seg == 0)
            r = 0;
         else if (seg == 1)
            r = 2;
         else
            r = $urandom_range(9);
         case (r)
            0, 1: begin
               while (gen_count < smpq_pkg::SMPQ_DEPTH) begin
                  if ($urandom_range(9) == 0)
                     add_cmd(smpq_pkg::OP_PEEK, $urandom);
                  else
                     add_cmd(smpq_pkg::OP_INSERT, pick_key(mode));
               end
               n = $urandom_range(3, 1);
               for (int i = 0; i < n; i++)
                  add_cmd(smpq_pkg::OP_INSERT, pick_key(mode));
            end
            2, 3: begin
               while (gen_count > 0) begin
                  if ($urandom_range(9) == 0)
                     add_cmd(smpq_pkg::OP_PEEK, $urandom);
                  else
                     add_cmd(smpq_pkg::OP_REMOVE, $urandom);
               end
               n = $urandom_range(2, 1);
               for (int i = 0; i < n; i++)
                  add_cmd(pick_read_op(), $urandom);
            end
            9: begin
               n = $urandom_range(10, 5);
               for (int i = 0; i < n; i++)
                  add_cmd($urandom_range(1) ? OP_UNUSED : pick_read_op(), $urandom);
            end
            default: begin
               n = $urandom_range(60, 20);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(99) < 50)
                     add_cmd(smpq_pkg::OP_INSERT, pick_key(mode));
                  else
                     add_cmd(pick_read_op(), $urandom);
               end
            end
         endcase
         seg++;
      end
      phase_len = cmd_backlog.size() / 3;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wait for every command to be taken, then every reply to arrive
      while (cmd_backlog.size() != 0 || req_chan.valid)
         @(posedge clock);
      guard = 0;
      while (expected_replies.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);

      if (mismatch_cnt == 0 && expected_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   // request driver: predicts each beat as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid  <= 1'b0;
         req_chan.op     <= smpq_pkg::OP_INSERT;
         req_chan.key_in <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_replies.push_back(apply_queue_op(req_chan.op, req_chan.key_in));
            beats_taken <= beats_taken + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
               req_chan.valid  <= 1'b1;
               req_chan.op     <= cmd_backlog[0].op;
               req_chan.key_in <= cmd_backlog[0].key;
               void'(cmd_backlog.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off after ten beats of the no-idle phase
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && beats_taken >= 2 * phase_len + 10) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // receiver ready
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
   end

   // response monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin
      queue_reply_type exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_replies.size() == 0) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < MAX_REPORTS)
               $display("unexpected response beat: key %0d status %0d occ %0d",
                        rsp_chan.key_out, rsp_chan.status, rsp_chan.occupancy);
         end else begin
            exp_r = expected_replies.pop_front();
            if (rsp_chan.key_out !== exp_r.key || rsp_chan.status !== exp_r.status ||
                rsp_chan.occupancy !== exp_r.occ) begin
               mismatch_cnt <= mismatch_cnt + 1;
               if (mismatch_cnt < MAX_REPORTS)
                  $display("mismatch: key exp %0d got %0d, st exp %0d got %0d, %s %0d got %0d",
                           exp_r.key, rsp_chan.key_out, exp_r.status, rsp_chan.status,
                           "occ exp", exp_r.occ, rsp_chan.occupancy);
            end
         end
      end
   end

endmodule
